FILE: rtl/sqd4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqd4_pkg
// widths, saturation limit and beat types shared by the four-way squared
// distance unit
// ----------------------------------------------------------------------------
package sqd4_pkg;

    localparam int unsigned MAX_DIM = 4096;

    localparam int unsigned ELEM_W  = 8;
    localparam int unsigned DIFF_W  = ELEM_W + 1;
    localparam int unsigned PROD_W  = 2 * DIFF_W;
    localparam int unsigned SQ_W    = 2 * ELEM_W;
    localparam int unsigned DIST_W  = 28;
    localparam int unsigned SUM_W   = DIST_W + 1;

    localparam longint unsigned SQ_MAX     = 64'd65025;
    localparam longint unsigned DIST_MAX   = (64'd1 << DIST_W) - 64'd1;
    localparam longint unsigned LIMIT_FULL = SQ_MAX * 64'(MAX_DIM);
    localparam logic [DIST_W-1:0] DIST_LIMIT =
        (LIMIT_FULL > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(LIMIT_FULL);

    typedef struct packed {
        logic signed [ELEM_W-1:0] query_elem;
        logic signed [ELEM_W-1:0] cand_a_elem;
        logic signed [ELEM_W-1:0] cand_b_elem;
        logic signed [ELEM_W-1:0] cand_c_elem;
        logic signed [ELEM_W-1:0] cand_d_elem;
        logic                     is_last;
    } t_in_beat;

    typedef struct packed {
        logic [DIST_W-1:0] dist_a;
        logic [DIST_W-1:0] dist_b;
        logic [DIST_W-1:0] dist_c;
        logic [DIST_W-1:0] dist_d;
    } t_out_beat;

    typedef struct packed {
        logic sq_load;
        logic acc_step;
        logic acc_clear;
    } t_lane_ctl;

endpackage

FILE: rtl/sqd4_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqd4_if
// valid/ready channels for input beats and result beats
// ----------------------------------------------------------------------------
interface sqd4_in_if import sqd4_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sqd4_out_if import sqd4_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/sqd4_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqd4_lane
// one candidate lane: registered squared difference and saturating
// accumulator
// ----------------------------------------------------------------------------
module sqd4_lane import sqd4_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_lane_ctl                i_ctl,
    input  logic signed [ELEM_W-1:0] i_query,
    input  logic signed [ELEM_W-1:0] i_cand,
    output logic [DIST_W-1:0]        o_sum
);

    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W-1:0] prod;
    logic [SQ_W-1:0]          n_sq;
    logic [SQ_W-1:0]          r_sq;
    logic [DIST_W-1:0]        r_acc;
    logic [SUM_W-1:0]         sum;

    assign diff = DIFF_W'(i_query) - DIFF_W'(i_cand);
    assign prod = diff * diff;
    assign n_sq = prod[SQ_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq <= '0;
        end else if (i_ctl.sq_load) begin
            r_sq <= n_sq;
        end
    end

    assign sum   = SUM_W'(r_acc) + SUM_W'(r_sq);
    assign o_sum = (sum > SUM_W'(DIST_LIMIT)) ? DIST_LIMIT : sum[DIST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.acc_step) begin
            r_acc <= i_ctl.acc_clear ? '0 : o_sum;
        end
    end

`ifndef SYNTH
    a_acc_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= DIST_LIMIT)
        else $error("lane accumulator above distance limit");

    a_acc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.acc_step && i_ctl.acc_clear |=> r_acc == '0)
        else $error("lane accumulator not cleared after last beat");

    a_sum_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_sum <= DIST_LIMIT && o_sum >= r_acc)
        else $error("lane sum not monotonic or above limit");
`endif

endmodule

FILE: rtl/int8_squared_distance_four_way_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_squared_distance_four_way_unit
// streams one query vector against four candidates, one dimension per beat,
// and returns the four squared euclidean distances on the last beat
// ----------------------------------------------------------------------------
// One input beat is taken every clock cycle while input is not stalled. A beat
// passes an input register, a register of the four squared differences, and
// the four accumulators; a beat marked last loads the result register with
// the final lane sums. Input stalls only while a last beat waits on a
// result register whose previous beat has not been taken. Each lane saturates
// at 65025 * MAX_DIM, capped at the 28-bit maximum, and clears after the last
// beat so the next vector starts from zero.
module int8_squared_distance_four_way_unit import sqd4_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sqd4_in_if.sink        i_in,
    sqd4_out_if.source     o_out
);

    logic      r_in_valid;
    t_in_beat  r_in;
    logic      r_sq_valid;
    logic      r_sq_last;
    logic      r_out_valid;
    t_out_beat r_out;

    logic      out_free;
    logic      acc_step;
    logic      sq_free;
    logic      in_free;
    t_lane_ctl lane_ctl;
    t_out_beat n_out;

    assign out_free = !r_out_valid || o_out.ready;
    assign acc_step = r_sq_valid && (!r_sq_last || out_free);
    assign sq_free  = !r_sq_valid || acc_step;
    assign in_free  = !r_in_valid || sq_free;

    assign i_in.ready = in_free;

    assign lane_ctl.sq_load   = r_in_valid && sq_free;
    assign lane_ctl.acc_step  = acc_step;
    assign lane_ctl.acc_clear = r_sq_last;

    sqd4_lane u_lane_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_query (r_in.query_elem),
        .i_cand  (r_in.cand_a_elem),
        .o_sum   (n_out.dist_a)
    );

    sqd4_lane u_lane_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_query (r_in.query_elem),
        .i_cand  (r_in.cand_b_elem),
        .o_sum   (n_out.dist_b)
    );

    sqd4_lane u_lane_c (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_query (r_in.query_elem),
        .i_cand  (r_in.cand_c_elem),
        .o_sum   (n_out.dist_c)
    );

    sqd4_lane u_lane_d (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lane_ctl),
        .i_query (r_in.query_elem),
        .i_cand  (r_in.cand_d_elem),
        .o_sum   (n_out.dist_d)
    );

    // input beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_free) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_free && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    // squared difference stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
            r_sq_last  <= 1'b0;
        end else if (sq_free) begin
            r_sq_valid <= r_in_valid;
            r_sq_last  <= r_in_valid && r_in.is_last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (acc_step && r_sq_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_step && r_sq_last) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTH
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_sq_valid && r_sq_last))
        else $error("result beat without a last beat");

    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sq_valid && r_sq_last && r_out_valid && !o_out.ready
        |=> r_sq_valid && r_sq_last)
        else $error("last beat dropped while result register full");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |-> !(acc_step && r_sq_last))
        else $error("result register overwritten before it was taken");
`endif

endmodule

FILE: bench/int8_squared_distance_four_way_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_squared_distance_four_way_unit_checker
// watches the input and result channels of the four-way squared distance
// unit, keeps its own four lane sums, predicts the distances of every vector
// and compares each result beat with the oldest prediction
// ----------------------------------------------------------------------------
module int8_squared_distance_four_way_unit_checker import sqd4_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sqd4_in_if   i_in,
    sqd4_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_dist_count,
    output int   o_sat_count
);

    logic [DIST_W-1:0] dist_sum_a;
    logic [DIST_W-1:0] dist_sum_b;
    logic [DIST_W-1:0] dist_sum_c;
    logic [DIST_W-1:0] dist_sum_d;
    t_out_beat         expected_dists[$];
    int                fail_total = 0;
    int                dist_total = 0;
    int                sat_total  = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = expected_dists.size();
    assign o_dist_count = dist_total;
    assign o_sat_count  = sat_total;

    function automatic logic [DIST_W-1:0] add_squared_diff(
        input logic [DIST_W-1:0]        sum,
        input logic signed [ELEM_W-1:0] q,
        input logic signed [ELEM_W-1:0] c
    );
        int     diff;
        longint total;
        diff  = int'(q) - int'(c);
        total = longint'(sum) + longint'(diff * diff);
        if (total > longint'(DIST_LIMIT)) begin
            total = longint'(DIST_LIMIT);
        end
        return DIST_W'(total);
    endfunction

    task automatic report_fail(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_total++;
    endtask

    task automatic compare_dist(input string lane, input logic [DIST_W-1:0] got,
                                input logic [DIST_W-1:0] want);
        if (got !== want) begin
            report_fail($sformatf("%s got %0d expected %0d", lane, got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat got;
        t_out_beat want;
        t_in_beat  beat;
        if (!i_rst_n) begin
            dist_sum_a = '0;
            dist_sum_b = '0;
            dist_sum_c = '0;
            dist_sum_d = '0;
            expected_dists.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got = i_out.data;
                dist_total++;
                if (expected_dists.size() == 0) begin
                    report_fail($sformatf("result beat with nothing expected (%0d %0d %0d %0d)",
                                          got.dist_a, got.dist_b, got.dist_c, got.dist_d));
                end else begin
                    want = expected_dists.pop_front();
                    compare_dist("dist_a", got.dist_a, want.dist_a);
                    compare_dist("dist_b", got.dist_b, want.dist_b);
                    compare_dist("dist_c", got.dist_c, want.dist_c);
                    compare_dist("dist_d", got.dist_d, want.dist_d);
                end
            end
            if (i_in.valid && i_in.ready) begin
                beat       = i_in.data;
                dist_sum_a = add_squared_diff(dist_sum_a, beat.query_elem, beat.cand_a_elem);
                dist_sum_b = add_squared_diff(dist_sum_b, beat.query_elem, beat.cand_b_elem);
                dist_sum_c = add_squared_diff(dist_sum_c, beat.query_elem, beat.cand_c_elem);
                dist_sum_d = add_squared_diff(dist_sum_d, beat.query_elem, beat.cand_d_elem);
                if (beat.is_last) begin
                    want.dist_a = dist_sum_a;
                    want.dist_b = dist_sum_b;
                    want.dist_c = dist_sum_c;
                    want.dist_d = dist_sum_d;
                    expected_dists.push_back(want);
                    if (dist_sum_a == DIST_LIMIT || dist_sum_b == DIST_LIMIT ||
                        dist_sum_c == DIST_LIMIT || dist_sum_d == DIST_LIMIT) begin
                        sat_total++;
                    end
                    dist_sum_a = '0;
                    dist_sum_b = '0;
                    dist_sum_c = '0;
                    dist_sum_d = '0;
                end
            end
        end
    end

endmodule

FILE: bench/int8_squared_distance_four_way_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int8_squared_distance_four_way_unit_test
// streams short, random and very long vectors into the four-way squared
// distance unit with bursty input and a stalling receiver, and leaves the
// checking to the checker module beside it
// ----------------------------------------------------------------------------
module int8_squared_distance_four_way_unit_test;
    import sqd4_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_BEATS = 1600;
    localparam int LONG_HOLD    = 400;

    typedef enum int {
        RX_ALWAYS,
        RX_HALF,
        RX_MOSTLY,
        RX_SPARSE,
        RX_EVERY_THIRD
    } t_rx_mode;

    logic i_clk;
    logic i_rst_n;

    sqd4_in_if  in_ch ();
    sqd4_out_if out_ch ();

    int fail_count;
    int dist_pending;
    int dist_count;
    int sat_count;
    int n_sent      = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    int8_squared_distance_four_way_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    int8_squared_distance_four_way_unit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (dist_pending),
        .o_dist_count (dist_count),
        .o_sat_count  (sat_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("int8_squared_distance_four_way_unit_test failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    function automatic t_in_beat make_beat(
        input logic signed [ELEM_W-1:0] q,
        input logic signed [ELEM_W-1:0] a,
        input logic signed [ELEM_W-1:0] b,
        input logic signed [ELEM_W-1:0] c,
        input logic signed [ELEM_W-1:0] d,
        input logic                     last
    );
        t_in_beat beat;
        beat.query_elem  = q;
        beat.cand_a_elem = a;
        beat.cand_b_elem = b;
        beat.cand_c_elem = c;
        beat.cand_d_elem = d;
        beat.is_last     = last;
        return beat;
    endfunction

    function automatic logic signed [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return 8'sh7f;
            1:       return 8'sh80;
            2:       return 8'sh00;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    function automatic int pick_dims();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return $urandom_range(1, 6);
        end else if (roll < 95) begin
            return $urandom_range(7, 40);
        end
        return $urandom_range(41, 200);
    endfunction

    task automatic send_beat(input t_in_beat beat);
        @(negedge i_clk);
        in_ch.valid <= 1'b1;
        in_ch.data  <= beat;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        n_sent++;
    endtask

    task automatic hold_valid_low(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end
    endtask

    // bursts of random length, sometimes back to back
    task automatic offer_beat(input t_in_beat beat);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                hold_valid_low($urandom_range(1, 8));
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        send_beat(beat);
    endtask

    task automatic wait_for_results();
        do begin
            @(negedge i_clk);
            in_ch.valid <= 1'b0;
        end while (dist_pending != 0);
    endtask

    // lanes a and b at full difference every dimension, lane d at zero
    task automatic send_far_vector(input int dims);
        logic signed [ELEM_W-1:0] q;
        for (int k = 0; k < dims; k++) begin
            q = $urandom_range(0, 1) ? 8'sh7f : 8'sh80;
            offer_beat(make_beat(q, ~q, ~q, rand_elem(), q, k == dims - 1));
        end
    endtask

    // receiver
    initial begin
        t_rx_mode mode;
        int       seg_left;
        bit       first_hold_done;
        bit       second_hold_done;
        mode             = RX_ALWAYS;
        seg_left         = 0;
        first_hold_done  = 1'b0;
        second_hold_done = 1'b0;
        out_ch.ready     = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if ((!first_hold_done && n_sent >= 200) ||
                (!second_hold_done && n_sent >= 400)) begin
                if (first_hold_done) begin
                    second_hold_done = 1'b1;
                end else begin
                    first_hold_done = 1'b1;
                end
                out_ch.ready <= 1'b0;
                for (int hold = 1; hold < LONG_HOLD; hold++) @(negedge i_clk);
            end else begin
                if (seg_left == 0) begin
                    mode     = t_rx_mode'($urandom_range(0, 4));
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (mode)
                    RX_ALWAYS:  out_ch.ready <= 1'b1;
                    RX_HALF:    out_ch.ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY:  out_ch.ready <= ($urandom_range(0, 9) != 0);
                    RX_SPARSE:  out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:    out_ch.ready <= (seg_left % 3 == 0);
                endcase
            end
        end
    end

    // sender and verdict
    initial begin
        int random_beats;
        int dims;
        bit exact_done;
        bit over_done;
        bit drained_mid;
        random_beats = 0;
        exact_done   = 1'b0;
        over_done    = 1'b0;
        drained_mid  = 1'b0;
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        in_ch.data   = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single-beat vectors at the extremes
        offer_beat(make_beat(8'sh00, 8'sh00, 8'sh00, 8'sh00, 8'sh00, 1'b1));
        offer_beat(make_beat(8'sh7f, 8'sh80, 8'sh7f, 8'sh00, 8'shff, 1'b1));
        offer_beat(make_beat(8'sh80, 8'sh7f, 8'sh80, 8'shff, 8'sh00, 1'b1));
        // multi-beat vectors, alternating bit patterns
        offer_beat(make_beat(8'sh7f, 8'sh80, 8'sh80, 8'sh7f, 8'sh80, 1'b0));
        offer_beat(make_beat(8'sh80, 8'sh7f, 8'sh7f, 8'sh80, 8'sh7f, 1'b0));
        offer_beat(make_beat(8'sh55, 8'shaa, 8'sh55, 8'shff, 8'sh00, 1'b1));
        offer_beat(make_beat(8'shaa, 8'sh55, 8'shaa, 8'sh00, 8'shff, 1'b0));
        offer_beat(make_beat(8'sh01, 8'shff, 8'sh02, 8'shfe, 8'sh40, 1'b1));
        offer_beat(make_beat(8'shc0, 8'sh3f, 8'sh00, 8'sh7f, 8'sh80, 1'b0));
        offer_beat(make_beat(8'sh00, 8'sh00, 8'sh00, 8'sh00, 8'sh00, 1'b0));
        offer_beat(make_beat(8'sh3f, 8'shc0, 8'sh7f, 8'sh80, 8'sh01, 1'b1));
        offer_beat(make_beat(rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                             rand_elem(), 1'b1));
        wait_for_results();

        while (random_beats < RANDOM_BEATS) begin
            if (!exact_done && random_beats >= 500) begin
                exact_done = 1'b1;
                send_far_vector(MAX_DIM);
            end else if (!over_done && random_beats >= 1000) begin
                over_done = 1'b1;
                send_far_vector(MAX_DIM + 104);
            end
            dims = pick_dims();
            for (int k = 0; k < dims; k++) begin
                offer_beat(make_beat(rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                                     rand_elem(), k == dims - 1));
                random_beats++;
            end
            if (!drained_mid && random_beats >= 800) begin
                drained_mid = 1'b1;
                wait_for_results();
            end
        end

        wait_for_results();
        hold_valid_low(10);

        $display("run covered %0d input beats and %0d distance results", n_sent, dist_count);
        $display("%0d results carried a saturated lane", sat_count);
        if (fail_count == 0 && dist_pending == 0) begin
            $display("int8_squared_distance_four_way_unit_test passed");
        end else begin
            $display("int8_squared_distance_four_way_unit_test failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sqd4_pkg.sv
rtl/sqd4_if.sv
rtl/sqd4_lane.sv
rtl/int8_squared_distance_four_way_unit.sv
bench/int8_squared_distance_four_way_unit_checker.sv
bench/int8_squared_distance_four_way_unit_test.sv
